// ----- rtl/irr_pkg.sv -----
// Shared types and constants of the interval range remapper.
package irr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned WIDE_W = WORD_W + 1;
    localparam int unsigned SLOT_W = 4;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_MAP   = 2'd2
    } t_command;

    typedef struct packed {
        t_command            command;
        logic [SLOT_W-1:0]   entry_index;
        logic [WORD_W-1:0]   src_start;
        logic [WORD_W-1:0]   dst_start;
        logic [WORD_W-1:0]   range_length;
        logic [WORD_W-1:0]   query_start;
        logic [WORD_W-1:0]   query_length;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] piece_start;
        logic [WORD_W-1:0] piece_length;
        logic              last;
    } t_piece;

    typedef struct packed {
        logic [WORD_W-1:0] src;
        logic [WORD_W-1:0] dst;
        logic [WORD_W-1:0] len;
    } t_entry;

endpackage

// ----- rtl/irr_stream_if.sv -----
// Valid/ready stream channel carrying one payload per beat.
interface irr_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/irr_table.sv -----
// Range table: entry memory with registered read and per-entry valid flags.
module irr_table #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  irr_pkg::t_entry      i_wr_entry,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output irr_pkg::t_entry      o_rd_entry,
    output logic                 o_rd_valid
);

    irr_pkg::t_entry  r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] n_valid;
    irr_pkg::t_entry  r_rd_entry;
    logic             r_rd_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_clear) begin
            n_valid = '0;
        end else if (i_wr_en) begin
            n_valid[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;

endmodule

// ----- rtl/irr_addsub.sv -----
// Shared 33-bit adder/subtractor used by the scan and arithmetic steps of the mapping sequence.
module irr_addsub (
    input  logic [irr_pkg::WIDE_W-1:0] i_a,
    input  logic [irr_pkg::WIDE_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [irr_pkg::WIDE_W-1:0] o_sum
);

    logic [irr_pkg::WIDE_W-1:0] b_eff;

    assign b_eff = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + b_eff + {{(irr_pkg::WIDE_W-1){1'b0}}, i_sub};

endmodule

// ----- rtl/interval_range_remap.sv -----
// Interval range remapper top level: command channel in, translated pieces out.
// Clear and write commands are taken while idle and leave the block idle. A map
// command walks its interval piece by piece; each piece scans the table one
// entry per cycle through its single read port, stopping at the first matching
// entry, then works span, offset, start, remainder and position through one
// shared 33-bit adder and hands the piece to the output register. A piece waits
// in the emit step while the output register is full and the sink holds back.
// Up to 2*TABLE_DEPTH+1 pieces can arise. A map of length zero returns at once
// with no piece. The command channel is ready only between commands, while the
// output register lets the final piece wait for the sink as the next command is
// taken.
module interval_range_remap #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    irr_stream_if.sink       i_cmd,
    irr_stream_if.source     o_piece
);

    localparam int unsigned IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned MAX_PIECES = 2 * TABLE_DEPTH + 1;
    localparam int unsigned CNT_W      = $clog2(MAX_PIECES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(MAX_PIECES - 1);

    localparam int unsigned W  = irr_pkg::WORD_W;
    localparam int unsigned WW = irr_pkg::WIDE_W;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SCAN    = 8'b0000_0010,
        ST_SPAN    = 8'b0000_0100,
        ST_OFFS    = 8'b0000_1000,
        ST_START   = 8'b0001_0000,
        ST_ADV_REM = 8'b0010_0000,
        ST_ADV_CUR = 8'b0100_0000,
        ST_EMIT    = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [WW-1:0]     r_cur, n_cur;
    logic [W-1:0]      r_rem, n_rem;
    logic [W-1:0]      r_near, n_near;
    logic              r_have_above, n_have_above;
    logic              r_hit, n_hit;
    logic [W-1:0]      r_hit_src, n_hit_src;
    logic [W-1:0]      r_hit_dst, n_hit_dst;
    logic [WW-1:0]     r_hit_end, n_hit_end;
    logic [WW-1:0]     r_span, n_span;
    logic [WW-1:0]     r_offs, n_offs;
    logic [W-1:0]      r_piece, n_piece;
    logic [W-1:0]      r_start, n_start;
    logic              r_out_valid, n_out_valid;
    irr_pkg::t_piece   r_out, n_out;

    irr_pkg::t_cmd     cmd;
    logic              cmd_fire;
    logic              tbl_clear;
    logic              tbl_wr;
    irr_pkg::t_entry   tbl_wr_entry;
    logic [IDX_W-1:0]  tbl_rd_addr;
    irr_pkg::t_entry   rd_entry;
    logic              rd_valid;

    logic [WW-1:0]     alu_a, alu_b, alu_sum;
    logic              alu_sub;

    logic [WW-1:0]     src_wide;
    logic              hit_now;
    logic              above_now;
    logic              bounded;
    logic              out_free;

    assign cmd          = i_cmd.data;
    assign i_cmd.ready  = (r_state == ST_IDLE);
    assign cmd_fire     = i_cmd.valid && (r_state == ST_IDLE);
    assign tbl_clear    = cmd_fire && (cmd.command == irr_pkg::CMD_CLEAR);
    assign tbl_wr       = cmd_fire && (cmd.command == irr_pkg::CMD_WRITE)
                          && (32'(cmd.entry_index) < 32'(TABLE_DEPTH));
    assign tbl_wr_entry = '{src: cmd.src_start, dst: cmd.dst_start, len: cmd.range_length};

    // Prefetch the next entry while scanning; otherwise keep entry 0 ready.
    assign tbl_rd_addr  = (r_state == ST_SCAN && r_idx != LAST_IDX)
                          ? r_idx + IDX_W'(1) : '0;

    irr_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (tbl_clear),
        .i_wr_en    (tbl_wr),
        .i_wr_addr  (IDX_W'(cmd.entry_index)),
        .i_wr_entry (tbl_wr_entry),
        .i_rd_addr  (tbl_rd_addr),
        .o_rd_entry (rd_entry),
        .o_rd_valid (rd_valid)
    );

    irr_addsub u_addsub (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    // Operand selection for the shared adder, at most one use per sequencer step.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            ST_SCAN: begin
                alu_a = {1'b0, rd_entry.src};
                alu_b = {1'b0, rd_entry.len};
            end
            ST_SPAN: begin
                alu_a   = r_hit ? r_hit_end : {1'b0, r_near};
                alu_b   = r_cur;
                alu_sub = 1'b1;
            end
            ST_OFFS: begin
                alu_a   = r_cur;
                alu_b   = {1'b0, r_hit_src};
                alu_sub = 1'b1;
            end
            ST_START: begin
                alu_a = r_hit ? {1'b0, r_hit_dst} : '0;
                alu_b = r_hit ? r_offs : r_cur;
            end
            ST_ADV_REM: begin
                alu_a   = {1'b0, r_rem};
                alu_b   = {1'b0, r_piece};
                alu_sub = 1'b1;
            end
            ST_ADV_CUR: begin
                alu_a = r_cur;
                alu_b = {1'b0, r_piece};
            end
            ST_IDLE, ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign src_wide  = {1'b0, rd_entry.src};
    assign hit_now   = rd_valid && (r_cur >= src_wide) && (r_cur < alu_sum);
    assign above_now = rd_valid && (src_wide > r_cur)
                       && (!r_have_above || rd_entry.src < r_near);
    assign bounded   = r_hit || r_have_above;
    assign out_free  = !r_out_valid || o_piece.ready;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_cur        = r_cur;
        n_rem        = r_rem;
        n_near       = r_near;
        n_have_above = r_have_above;
        n_hit        = r_hit;
        n_hit_src    = r_hit_src;
        n_hit_dst    = r_hit_dst;
        n_hit_end    = r_hit_end;
        n_span       = r_span;
        n_offs       = r_offs;
        n_piece      = r_piece;
        n_start      = r_start;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_piece.ready;

        unique case (r_state)
            ST_IDLE: begin
                if (cmd_fire && cmd.command == irr_pkg::CMD_MAP
                    && cmd.query_length != '0) begin
                    n_cur        = {1'b0, cmd.query_start};
                    n_rem        = cmd.query_length;
                    n_count      = '0;
                    n_idx        = '0;
                    n_have_above = 1'b0;
                    n_hit        = 1'b0;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (above_now) begin
                    n_near       = rd_entry.src;
                    n_have_above = 1'b1;
                end
                if (hit_now) begin
                    n_hit     = 1'b1;
                    n_hit_src = rd_entry.src;
                    n_hit_dst = rd_entry.dst;
                    n_hit_end = alu_sum;
                    n_state   = ST_SPAN;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_SPAN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_SPAN: begin
                n_span  = alu_sum;
                n_state = ST_OFFS;
            end
            ST_OFFS: begin
                n_offs  = alu_sum;
                // Clip to the remaining length unless a boundary comes first.
                n_piece = (bounded && r_span < {1'b0, r_rem}) ? r_span[W-1:0] : r_rem;
                n_state = ST_START;
            end
            ST_START: begin
                n_start = alu_sum[W-1:0];
                n_state = ST_ADV_REM;
            end
            ST_ADV_REM: begin
                n_rem   = alu_sum[W-1:0];
                n_state = ST_ADV_CUR;
            end
            ST_ADV_CUR: begin
                n_cur   = alu_sum;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the output register frees up.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{piece_start:  r_start,
                                    piece_length: r_piece,
                                    last:         (r_rem == '0)};
                    n_count      = r_count + CNT_W'(1);
                    n_idx        = '0;
                    n_have_above = 1'b0;
                    n_hit        = 1'b0;
                    if (r_rem == '0 || r_count == LAST_CNT) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_count      <= n_count;
        r_cur        <= n_cur;
        r_rem        <= n_rem;
        r_near       <= n_near;
        r_have_above <= n_have_above;
        r_hit        <= n_hit;
        r_hit_src    <= n_hit_src;
        r_hit_dst    <= n_hit_dst;
        r_hit_end    <= n_hit_end;
        r_span       <= n_span;
        r_offs       <= n_offs;
        r_piece      <= n_piece;
        r_start      <= n_start;
        r_out        <= n_out;
    end

    assign o_piece.valid = r_out_valid;
    assign o_piece.data  = r_out;

endmodule
